>>> sv/ffha_pkg.sv
// Shared types, constants and helper functions of the first-fit heap allocator.
`timescale 1ns / 1ps
package ffha_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int HEADER_BYTES = 20;
  localparam int SPLIT_SLACK  = 32;
  localparam logic [31:0] RESET_BASE = 32'h0010_0000;
  localparam logic [31:0] RESET_SIZE = 32'h0010_0000;
  localparam int IN_W  = 72;
  localparam int OUT_W = 136;

  typedef enum logic [1:0] {
    OPC_INIT  = 2'd0,
    OPC_ALLOC = 2'd1,
    OPC_FREE  = 2'd2,
    OPC_NONE  = 2'd3
  } opc_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_ZERO    = 2'd1,
    ST_NOFIT   = 2'd2,
    ST_IGNORED = 2'd3
  } st_t;

  typedef enum logic {
    CFG_HEAP_BASE = 1'b0,
    CFG_HEAP_SIZE = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic        used;
    logic [31:0] len;
    logic [31:0] off;
  } ent_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_BOOT, DP_LOAD, DP_STAT, DP_INIT, DP_RD_IDX, DP_NEXT, DP_TAKE,
    DP_SH_INIT, DP_SH_RD, DP_SH_WR, DP_WR_SPLIT, DP_WR_ALLOC, DP_REL_MARK,
    DP_RD_KM1, DP_TAKE_PREV, DP_RD_KP1, DP_MERGE, DP_RM_RD, DP_RM_WR,
    DP_CNT_DEC, DP_WR_CUR, DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    st_t    st;
  } dp_cmd_t;

  typedef struct packed {
    opc_t opc;
    logic req_zero;
    logic need_ovf;
    logic rel_zero;
    logic idx_end;
    logic hit;
    logic split_ok;
    logic j_gt_kp1;
    logic k_nz;
    logic rd_free;
    logic kp1_lt;
    logic jp1_lt;
    logic out_free;
  } dp_stat_t;

  typedef enum logic [4:0] {
    S_BOOT, S_IDLE, S_DECODE, S_INIT, S_SCAN_RD, S_SCAN_CHK, S_ALLOC_DEC,
    S_SH_RD, S_SH_WR, S_ALLOC_WR, S_REL_MARK, S_PRV_RD, S_PRV_CHK,
    S_MRG_RD, S_MRG_CHK, S_RM_RD, S_RM_WR, S_MRG_WR, S_DONE
  } state_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] b);
    return (a > b) ? (a - b) : 32'd0;
  endfunction

endpackage

>>> sv/ffha_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/ffha_ctrl.sv
// Controller state machine that sequences scans, shifts and merges.
`timescale 1ns / 1ps
module ffha_ctrl import ffha_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_BOOT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_BOOT: state_next = S_IDLE;
      S_IDLE: if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        case (stat.opc)
          OPC_INIT:  state_next = S_INIT;
          OPC_ALLOC: state_next = (stat.req_zero || stat.need_ovf) ? S_DONE : S_SCAN_RD;
          OPC_FREE:  state_next = stat.rel_zero ? S_DONE : S_SCAN_RD;
          default:   state_next = S_DONE;
        endcase
      end
      S_INIT: state_next = S_DONE;
      S_SCAN_RD: state_next = stat.idx_end ? S_DONE : S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (!stat.hit) begin
          state_next = S_SCAN_RD;
        end else if (stat.opc == OPC_ALLOC) begin
          state_next = S_ALLOC_DEC;
        end else begin
          state_next = S_REL_MARK;
        end
      end
      S_ALLOC_DEC: state_next = stat.split_ok ? S_SH_RD : S_ALLOC_WR;
      S_SH_RD: state_next = stat.j_gt_kp1 ? S_SH_WR : S_ALLOC_WR;
      S_SH_WR: state_next = S_SH_RD;
      S_ALLOC_WR: state_next = S_DONE;
      S_REL_MARK: state_next = stat.k_nz ? S_PRV_RD : S_MRG_RD;
      S_PRV_RD: state_next = S_PRV_CHK;
      S_PRV_CHK: state_next = S_MRG_RD;
      S_MRG_RD: state_next = stat.kp1_lt ? S_MRG_CHK : S_MRG_WR;
      S_MRG_CHK: state_next = stat.rd_free ? S_RM_RD : S_MRG_WR;
      S_RM_RD: state_next = stat.jp1_lt ? S_RM_WR : S_MRG_RD;
      S_RM_WR: state_next = S_RM_RD;
      S_MRG_WR: state_next = S_DONE;
      S_DONE: if (stat.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op   = DP_NOP;
    cmd.st   = ST_IGNORED;
    in_ready = 1'b0;
    case (state)
      S_BOOT: cmd.op = DP_BOOT;
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = DP_LOAD;
      end
      S_DECODE: begin
        case (stat.opc)
          OPC_INIT: cmd.op = DP_NOP;
          OPC_ALLOC: begin
            if (stat.req_zero) begin
              cmd.op = DP_STAT;
              cmd.st = ST_ZERO;
            end else if (stat.need_ovf) begin
              cmd.op = DP_STAT;
              cmd.st = ST_NOFIT;
            end
          end
          OPC_FREE: begin
            if (stat.rel_zero) cmd.op = DP_STAT;
          end
          default: cmd.op = DP_STAT;
        endcase
      end
      S_INIT: cmd.op = DP_INIT;
      S_SCAN_RD: begin
        if (stat.idx_end) begin
          cmd.op = DP_STAT;
          cmd.st = (stat.opc == OPC_ALLOC) ? ST_NOFIT : ST_IGNORED;
        end else begin
          cmd.op = DP_RD_IDX;
        end
      end
      S_SCAN_CHK: cmd.op = stat.hit ? DP_TAKE : DP_NEXT;
      S_ALLOC_DEC: if (stat.split_ok) cmd.op = DP_SH_INIT;
      S_SH_RD: cmd.op = stat.j_gt_kp1 ? DP_SH_RD : DP_WR_SPLIT;
      S_SH_WR: cmd.op = DP_SH_WR;
      S_ALLOC_WR: cmd.op = DP_WR_ALLOC;
      S_REL_MARK: cmd.op = DP_REL_MARK;
      S_PRV_RD: cmd.op = DP_RD_KM1;
      S_PRV_CHK: if (stat.rd_free) cmd.op = DP_TAKE_PREV;
      S_MRG_RD: if (stat.kp1_lt) cmd.op = DP_RD_KP1;
      S_MRG_CHK: if (stat.rd_free) cmd.op = DP_MERGE;
      S_RM_RD: cmd.op = stat.jp1_lt ? DP_RM_RD : DP_CNT_DEC;
      S_RM_WR: cmd.op = DP_RM_WR;
      S_MRG_WR: cmd.op = DP_WR_CUR;
      S_DONE: if (stat.out_free) cmd.op = DP_OUT;
      default: cmd.op = DP_NOP;
    endcase
  end

endmodule

>>> sv/ffha_dp.sv
// Datapath: block table RAM, index counters, byte counters and the result register.
`timescale 1ns / 1ps
module ffha_dp import ffha_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic [IN_W-1:0]    in_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [OUT_W-1:0]   out_data
);

  logic [31:0]      heap_base, heap_size;
  opc_t             opc;
  logic             req_zero, rel_zero;
  logic [32:0]      need;
  logic [31:0]      rel;
  logic [CNT_W-1:0] cnt, idx, j;
  logic [IDX_W-1:0] k;
  logic [31:0]      cur_off, cur_len;
  logic [31:0]      used_total, free_total;
  st_t              st;
  logic [31:0]      addr;

  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  ent_t             wdata, rd;
  logic [IDX_W-1:0] k_p1, k_m1;
  logic [CNT_W-1:0] j_m1, j_p1, k_p1w;
  logic [32:0]      rounded;
  logic [33:0]      split_lim;

  assign k_p1  = k + IDX_W'(1);
  assign k_m1  = k - IDX_W'(1);
  assign j_m1  = j - CNT_W'(1);
  assign j_p1  = j + CNT_W'(1);
  assign k_p1w = {1'b0, k} + CNT_W'(1);
  assign rounded   = ({1'b0, in_data[33:2]} + 33'd3) & ~33'd3;
  assign split_lim = {1'b0, need} + 34'(SPLIT_SLACK);

  ffha_ram #(.WIDTH($bits(ent_t)), .DEPTH(MAX_BLOCKS)) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rd)
  );

  always_comb begin
    we    = 1'b0;
    waddr = k;
    wdata = '{used: 1'b0, len: cur_len, off: cur_off};
    raddr = idx[IDX_W-1:0];
    case (cmd.op)
      DP_BOOT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = '{used: 1'b0, len: RESET_SIZE, off: 32'd0};
      end
      DP_INIT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = '{used: 1'b0, len: heap_size, off: 32'd0};
      end
      DP_SH_RD:  raddr = j_m1[IDX_W-1:0];
      DP_SH_WR: begin
        we    = 1'b1;
        waddr = j[IDX_W-1:0];
        wdata = rd;
      end
      DP_WR_SPLIT: begin
        we    = 1'b1;
        waddr = k_p1;
        wdata = '{used: 1'b0, len: cur_len - need[31:0], off: cur_off + need[31:0]};
      end
      DP_WR_ALLOC: begin
        we    = 1'b1;
        wdata = '{used: 1'b1, len: cur_len, off: cur_off};
      end
      DP_REL_MARK, DP_WR_CUR: we = 1'b1;
      DP_RD_KM1: raddr = k_m1;
      DP_RD_KP1: raddr = k_p1;
      DP_RM_RD:  raddr = j_p1[IDX_W-1:0];
      DP_RM_WR: begin
        we    = 1'b1;
        waddr = j[IDX_W-1:0];
        wdata = rd;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base  <= RESET_BASE;
      heap_size  <= RESET_SIZE;
      cnt        <= CNT_W'(1);
      used_total <= 32'(HEADER_BYTES);
      free_total <= sat_sub(RESET_SIZE, 32'(HEADER_BYTES));
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_HEAP_BASE) begin
          heap_base <= cfg_data;
        end else begin
          heap_size <= cfg_data;
        end
      end
      if (cmd.op == DP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        DP_INIT: begin
          cnt        <= CNT_W'(1);
          used_total <= 32'(HEADER_BYTES);
          free_total <= sat_sub(heap_size, 32'(HEADER_BYTES));
        end
        DP_WR_SPLIT: cnt <= cnt + CNT_W'(1);
        DP_WR_ALLOC: begin
          used_total <= sat_add(used_total, cur_len);
          free_total <= sat_sub(free_total, cur_len);
        end
        DP_REL_MARK: begin
          used_total <= sat_sub(used_total, cur_len);
          free_total <= sat_add(free_total, cur_len);
        end
        DP_CNT_DEC: cnt <= cnt - CNT_W'(1);
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        opc      <= opc_t'(in_data[1:0]);
        req_zero <= (in_data[33:2] == 32'd0);
        need     <= rounded + 33'(HEADER_BYTES);
        rel      <= in_data[65:34];
        rel_zero <= (in_data[65:34] == 32'd0);
        idx      <= '0;
        st       <= ST_IGNORED;
        addr     <= 32'd0;
      end
      DP_STAT: begin
        st   <= cmd.st;
        addr <= 32'd0;
      end
      DP_INIT: begin
        st   <= ST_DONE;
        addr <= 32'd0;
      end
      DP_NEXT: idx <= idx + CNT_W'(1);
      DP_TAKE: begin
        cur_off <= rd.off;
        cur_len <= rd.len;
        k       <= idx[IDX_W-1:0];
      end
      DP_SH_INIT: j <= cnt;
      DP_SH_WR:   j <= j_m1;
      DP_WR_SPLIT: cur_len <= need[31:0];
      DP_WR_ALLOC: begin
        st   <= ST_DONE;
        addr <= heap_base + cur_off + 32'(HEADER_BYTES);
      end
      DP_REL_MARK: begin
        st   <= ST_DONE;
        addr <= 32'd0;
      end
      DP_TAKE_PREV: begin
        cur_off <= rd.off;
        cur_len <= rd.len;
        k       <= k_m1;
      end
      DP_MERGE: begin
        cur_len <= sat_add(cur_len, rd.len);
        j       <= k_p1w;
      end
      DP_RM_WR: j <= j_p1;
      DP_OUT: out_data <= {6'd0, free_total, used_total, heap_size, addr, st};
      default: j <= j;
    endcase
  end

  always_comb begin
    stat.opc      = opc;
    stat.req_zero = req_zero;
    stat.need_ovf = need[32];
    stat.rel_zero = rel_zero;
    stat.idx_end  = (idx >= cnt);
    if (opc == OPC_ALLOC) begin
      stat.hit = !rd.used && ({1'b0, rd.len} >= need);
    end else begin
      stat.hit = rd.used && ((heap_base + rd.off + 32'(HEADER_BYTES)) == rel);
    end
    stat.split_ok = ({2'b0, cur_len} > split_lim) && (cnt < CNT_W'(MAX_BLOCKS));
    stat.j_gt_kp1 = (j > k_p1w);
    stat.k_nz     = (k != '0);
    stat.rd_free  = !rd.used;
    stat.kp1_lt   = (k_p1w < cnt);
    stat.jp1_lt   = (j_p1 < cnt);
    stat.out_free = !out_valid || out_ready;
  end

endmodule

>>> sv/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator with coalescing.
//
// Commands arrive as beats on the s_axis channel: init (rebuild the table as
// one free block over heap_size), allocate, or release. Each command gives
// exactly one result beat on m_axis with status, payload address and the
// total, used and free byte counters. heap_base and heap_size are to be written
// through cfg_we / cfg_index / cfg_data while the block is idle; the block
// itself does not enforce this. One command is worked at a time. The block
// table sits in a RAM with one read and one write port, so the scan reads
// and checks one entry at a time, inserting a split entry moves each later
// entry up with a read and a write, and each merge moves each later entry
// down the same way.
// Reset rebuilds the register defaults and, in one cycle after reset, writes
// the single free block; s_axis_tready rises after that cycle.
// If the receiver stalls, the result is held in the output register and the
// block accepts the next command; that command finishes and waits until the
// earlier beat has been taken.
`timescale 1ns / 1ps
module first_fit_heap_allocator import ffha_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // opcode[1:0], request_size[33:2], release_address[65:34], zero fill
  input  logic [IN_W-1:0]   s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // status[1:0], payload_address[33:2], total_bytes[65:34],
  // used_bytes[97:66], free_bytes[129:98], zero fill
  output logic [OUT_W-1:0]  m_axis_tdata,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ffha_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  ffha_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (s_axis_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (m_axis_tdata)
  );

endmodule

>>> sv/ffha_checker.sv
// Port-level checker for the heap allocator and its bind to the top level.
`timescale 1ns / 1ps
module ffha_checker import ffha_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [OUT_W-1:0]  m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("command accepted while busy");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[1:0] != ST_DONE) |-> (m_axis_tdata[33:2] == 32'd0))
    else $error("failed command reports an address");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

>>> bench/tb_first_fit_heap_allocator.sv
// Self-checking testbench for the first-fit heap allocator.
`timescale 1ns / 1ps
module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] addr;
    logic [31:0] total;
    logic [31:0] used;
    logic [31:0] free_b;
  } alloc_result_t;

  // Behavioral copy of the allocator that predicts each result beat.
  class heap_scoreboard;
    logic [31:0] base_r, size_r;
    logic [31:0] offs[MAX_BLOCKS];
    logic [31:0] lens[MAX_BLOCKS];
    bit busy[MAX_BLOCKS];
    int count;
    logic [31:0] used_tot, free_tot;
    alloc_result_t pending[$];
    int errors;
    logic [31:0] live_addrs[$];

    function void rebuild();
      offs[0] = 0; lens[0] = size_r; busy[0] = 0; count = 1;
      used_tot = HEADER_BYTES;
      free_tot = sat_sub(size_r, HEADER_BYTES);
      live_addrs.delete();
    endfunction

    function void power_up();
      base_r = RESET_BASE; size_r = RESET_SIZE; errors = 0;
      rebuild();
    endfunction

    function void write_reg(cfg_idx_t idx, logic [31:0] val);
      if (idx == CFG_HEAP_BASE) base_r = val; else size_r = val;
    endfunction

    function logic [31:0] payload(int i);
      return base_r + offs[i] + HEADER_BYTES;
    endfunction

    function logic [1:0] allocate(logic [31:0] req, output logic [31:0] addr);
      logic [33:0] need;
      addr = 0;
      if (req == 0) return ST_ZERO;
      need = (({2'b0, req} + 34'd3) & ~34'd3) + HEADER_BYTES;
      if (need > 34'hFFFF_FFFF) return ST_NOFIT;
      for (int i = 0; i < count; i++) begin
        if (busy[i] || {2'b0, lens[i]} < need) continue;
        if ({2'b0, lens[i]} > need + SPLIT_SLACK && count < MAX_BLOCKS) begin
          for (int j = count; j > i + 1; j--) begin
            offs[j] = offs[j-1]; lens[j] = lens[j-1]; busy[j] = busy[j-1];
          end
          offs[i+1] = offs[i] + need[31:0];
          lens[i+1] = lens[i] - need[31:0];
          busy[i+1] = 0;
          lens[i] = need[31:0];
          count++;
        end
        busy[i] = 1;
        used_tot = sat_add(used_tot, lens[i]);
        free_tot = sat_sub(free_tot, lens[i]);
        addr = payload(i);
        live_addrs.push_back(addr);
        return ST_DONE;
      end
      return ST_NOFIT;
    endfunction

    function logic [1:0] release_block(logic [31:0] a);
      int i;
      if (a == 0) return ST_IGNORED;
      for (i = 0; i < count; i++) if (busy[i] && payload(i) == a) break;
      if (i >= count) return ST_IGNORED;
      busy[i] = 0;
      used_tot = sat_sub(used_tot, lens[i]);
      free_tot = sat_add(free_tot, lens[i]);
      if (i > 0 && !busy[i-1]) i--;
      while (i + 1 < count && !busy[i+1]) begin
        lens[i] = sat_add(lens[i], lens[i+1]);
        for (int j = i + 1; j + 1 < count; j++) begin
          offs[j] = offs[j+1]; lens[j] = lens[j+1]; busy[j] = busy[j+1];
        end
        count--;
      end
      return ST_DONE;
    endfunction

    function void note_command(opc_t op, logic [31:0] req, logic [31:0] rel);
      alloc_result_t r;
      r.addr = 0;
      case (op)
        OPC_INIT: begin
          rebuild(); r.status = ST_DONE;
        end
        OPC_ALLOC: r.status = allocate(req, r.addr);
        OPC_FREE: r.status = release_block(rel);
        default: r.status = ST_IGNORED;
      endcase
      r.total = size_r; r.used = used_tot; r.free_b = free_tot;
      pending.push_back(r);
    endfunction

    function void check_result(logic [OUT_W-1:0] data);
      alloc_result_t got, exp;
      // The port carries status in the lowest bits, the struct in the highest.
      got = {data[1:0], data[33:2], data[65:34], data[97:66], data[129:98]};
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result beat %h", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp || data[OUT_W-1:130] !== '0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: st %0d/%0d addr %h/%h tot %h/%h used %h/%h free %h/%h",
                   exp.status, got.status, exp.addr, got.addr, exp.total, got.total,
                   exp.used, got.used, exp.free_b, got.free_b);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid, m_axis_tready = 0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic cfg_we = 0, cfg_index = 0;
  logic [31:0] cfg_data = 0;
  heap_scoreboard board;
  int idle_cycles = 0;
  int stall_mode = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  first_fit_heap_allocator DUT (.*);

  // Receiver: pattern switches between always-ready, random and long stalls.
  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      default: m_axis_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("tb_first_fit_heap_allocator NOT OK");
      $finish;
    end
  end

  int gap_left = 0, burst_left = 0;

  task automatic send(opc_t op, logic [31:0] req, logic [31:0] rel);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
    end
    while (gap_left > 0) begin
      @(posedge clk);
      gap_left--;
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, rel, req, op};
    do @(posedge clk); while (!s_axis_tready);
    board.note_command(op, req, rel);
    s_axis_tvalid <= 1'b0;
    // The block is busy for at least this cycle after an accepted beat.
    @(posedge clk);
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (8 * MAX_BLOCKS + 20) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [31:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    board.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_release();
    int k;
    k = $urandom_range(0, 9);
    if (k < 7 && board.live_addrs.size() > 0)
      return board.live_addrs[$urandom_range(0, board.live_addrs.size() - 1)];
    if (k == 7) return 0;
    if (k == 8) return $urandom;
    return board.base_r + HEADER_BYTES;
  endfunction

  task automatic random_phase(int n, int max_req);
    int k;
    logic [31:0] a;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 2) send(OPC_INIT, $urandom, $urandom);
      else if (k < 4) send(OPC_NONE, $urandom, $urandom);
      else if (k < 6) send(OPC_ALLOC, $urandom, $urandom);
      else if (k < 55) send(OPC_ALLOC, $urandom_range(0, max_req), $urandom);
      else begin
        a = pick_release();
        send(OPC_FREE, $urandom, a);
      end
    end
  endtask

  initial begin
    logic [31:0] a1, a2, a3;
    board = new();
    board.power_up();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, zero size, oversize, each release case, opcode 3.
    send(OPC_ALLOC, 0, 0);
    send(OPC_ALLOC, 32'hFFFF_FFFF, 0);
    send(OPC_ALLOC, 32'hFFFF_FFEC, 0);
    send(OPC_ALLOC, 1, 0);
    a1 = board.live_addrs[0];
    send(OPC_ALLOC, 5, 0);
    send(OPC_ALLOC, 100, 0);
    a2 = board.live_addrs[1];
    a3 = board.live_addrs[2];
    send(OPC_ALLOC, 32'h0010_0000, 0);
    send(OPC_FREE, 0, 0);
    send(OPC_FREE, 0, 32'hFFFF_FFFF);
    send(OPC_FREE, 0, a2);
    send(OPC_FREE, 0, a2);
    send(OPC_FREE, 0, a1);
    send(OPC_FREE, 0, a3);
    send(OPC_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(OPC_ALLOC, 32'hFFFB_0000, 0);
    send(OPC_INIT, 0, 0);
    // Block split when the remainder is just over the split slack.
    send(OPC_ALLOC, 32'h000F_FFC8, 0);
    send(OPC_INIT, 0, 0);
    drain();

    // Small heap with wrapping base: table fills up and payloads wrap.
    write_cfg(CFG_HEAP_BASE, 32'hFFFF_FF00);
    write_cfg(CFG_HEAP_SIZE, 32'd4096);
    send(OPC_INIT, 0, 0);
    for (int i = 0; i < 70; i++) send(OPC_ALLOC, $urandom_range(1, 12), 0);
    random_phase(150, 64);
    drain();

    write_cfg(CFG_HEAP_SIZE, 32'd10);
    send(OPC_INIT, 0, 0);
    send(OPC_ALLOC, 1, 0);
    drain();

    write_cfg(CFG_HEAP_BASE, 32'h0);
    write_cfg(CFG_HEAP_SIZE, 32'hFFFF_FFFF);
    send(OPC_INIT, 0, 0);
    random_phase(250, 32'h0800_0000);
    drain();

    write_cfg(CFG_HEAP_SIZE, 32'h0);
    send(OPC_INIT, 0, 0);
    send(OPC_ALLOC, 4, 0);
    drain();

    write_cfg(CFG_HEAP_BASE, 32'h8000_0000);
    write_cfg(CFG_HEAP_SIZE, 32'd20000);
    send(OPC_INIT, 0, 0);
    random_phase(350, 600);
    drain();

    write_cfg(CFG_HEAP_BASE, RESET_BASE);
    write_cfg(CFG_HEAP_SIZE, RESET_SIZE);
    random_phase(300, 40000);

    drain();
    if (board.errors == 0 && board.pending.size() == 0)
      $display("tb_first_fit_heap_allocator OK");
    else
      $display("tb_first_fit_heap_allocator NOT OK");
    $finish;
  end
endmodule

>>> filelist.f
sv/ffha_pkg.sv
sv/ffha_ram.sv
sv/ffha_ctrl.sv
sv/ffha_dp.sv
sv/first_fit_heap_allocator.sv
sv/ffha_checker.sv
bench/tb_first_fit_heap_allocator.sv
